/* rtl/lead_lag_load_sharing_macros.svh */
// Assertion macros shared by the lead/lag load sharing RTL.
`ifndef LEAD_LAG_LOAD_SHARING_MACROS_SVH
`define LEAD_LAG_LOAD_SHARING_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/lls_pkg.sv */
// Package with shared types and constants for the lead/lag load sharing block.
package lls_pkg;
    localparam int unsigned MEMBERS_DEF = 4;
    localparam int unsigned PCT = 100;
    // Width of the divider dividend, and so the number of restoring steps.
    localparam int unsigned DIV_W = 49;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_DEMAND = 2'd1,
        OP_ROTATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_COUNT    = 3'd0,
        CFG_WEAR     = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_ENABLE   = 3'd3,
        CFG_CAP0     = 3'd4,
        CFG_CAP1     = 3'd5,
        CFG_CAP2     = 3'd6,
        CFG_CAP3     = 3'd7
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;      // capture the input beat
        logic set_demand;
        logic timer_add;    // advance since_rotation and refresh availability
        logic rot_start;    // clear the rotation scan
        logic rot_step;     // visit one member for rotation
        logic rot_commit;   // apply the rotation result
        logic run_add;      // add elapsed time to one runtime
        logic sum_start;
        logic sum_step;     // accumulate one capacity
        logic sh_start;     // begin sharing pass
        logic sh_mul;       // form cap * demand
        logic div_start;    // start a division
        logic div_step;     // one restoring division step
        logic sh_share;     // take quotient as share
        logic sh_duty_mul;  // form share * 100
        logic sh_emit;      // load result register
        logic sh_skip;      // advance cursor past an unavailable member
        logic [1:0] idx;    // member index for per-member steps
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        t_op  op;
        logic enabled;
        logic rot_due;
        logic n_zero;
        logic total_zero;
        logic remaining_zero;
        logic cur_avail;
    } t_sts;
endpackage

/* rtl/lls_ctrl.sv */
// Controller state machine sequencing each operation over the datapath.
module lls_ctrl #(
    parameter int unsigned MEMBERS = lls_pkg::MEMBERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_res_free,
    input  logic [2:0]    i_n,
    input  lls_pkg::t_sts i_sts,
    output lls_pkg::t_cmd o_cmd
);
    localparam int unsigned DW = lls_pkg::DIV_W; // division steps over the dividend

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_ROT, S_RUN, S_SUM, S_SHCHK, S_MUL, S_DIV, S_SHARE,
        S_DMUL, S_DDIV, S_EMIT, S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_vis, n_vis;
    logic [5:0] r_cnt, n_cnt;
    logic [2:0] w_n;

    assign w_n = (i_n > 3'(MEMBERS)) ? 3'(MEMBERS) : i_n;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_vis = r_vis;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx = 2'd0;
                n_vis = 3'd0;
                o_cmd.rot_start = 1'b1;
                case (i_sts.op)
                    lls_pkg::OP_DEMAND: begin
                        o_cmd.set_demand = 1'b1;
                        n_state = S_IDLE;
                    end
                    lls_pkg::OP_ROTATE: n_state = i_sts.n_zero ? S_IDLE : S_ROT;
                    lls_pkg::OP_TICK: begin
                        o_cmd.timer_add = 1'b1;
                        if (!i_sts.enabled) n_state = S_IDLE;
                        else if (i_sts.rot_due && !i_sts.n_zero) n_state = S_ROT;
                        else n_state = i_sts.n_zero ? S_IDLE : S_RUN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Visit every member in use, then apply the pick in the cycle after the last visit.
            S_ROT: begin
                if (r_vis < w_n) begin
                    o_cmd.rot_step = 1'b1;
                    o_cmd.idx = r_vis[1:0];
                    n_vis = r_vis + 3'd1;
                end else begin
                    o_cmd.rot_commit = 1'b1;
                    n_idx = 2'd0;
                    n_state = (i_sts.op == lls_pkg::OP_TICK) ? S_RUN : S_IDLE;
                end
            end
            S_RUN: begin
                o_cmd.run_add = 1'b1;
                o_cmd.sum_start = (r_idx == 2'd0);
                if ({1'b0, r_idx} + 3'd1 >= w_n) begin
                    n_idx = 2'd0;
                    n_state = S_SUM;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if ({1'b0, r_idx} + 3'd1 >= w_n) begin
                    n_state = S_SHCHK;
                    n_vis = 3'd0;
                    o_cmd.sh_start = 1'b1;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_SHCHK: begin
                if (i_sts.total_zero || i_sts.remaining_zero || r_vis >= w_n) begin
                    n_state = S_IDLE;
                end else if (!i_sts.cur_avail) begin
                    o_cmd.sh_skip = 1'b1;
                    n_vis = r_vis + 3'd1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.sh_mul = 1'b1;
                n_state = S_DIV;
                n_cnt = 6'd0;
            end
            S_DIV: begin
                o_cmd.div_start = (r_cnt == 6'd0);
                o_cmd.div_step = (r_cnt != 6'd0);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DW)) n_state = S_SHARE;
            end
            S_SHARE: begin
                o_cmd.sh_share = 1'b1;
                n_state = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.sh_duty_mul = 1'b1;
                n_cnt = 6'd0;
                n_state = S_DDIV;
            end
            S_DDIV: begin
                o_cmd.div_start = (r_cnt == 6'd0);
                o_cmd.div_step = (r_cnt != 6'd0);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DW)) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_res_free) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.sh_emit = 1'b1;
                n_vis = r_vis + 3'd1;
                n_state = S_SHCHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= 2'd0;
            r_vis <= 3'd0;
            r_cnt <= 6'd0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_vis <= n_vis;
            r_cnt <= n_cnt;
        end
    end
endmodule

/* rtl/lls_dp.sv */
// Datapath: state registers, timer, rotation scan, runtimes, shared divider and result.
`include "lead_lag_load_sharing_macros.svh"
module lls_dp #(
    parameter int unsigned MEMBERS = lls_pkg::MEMBERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_operation,
    input  logic [15:0]   i_elapsed_ms,
    input  logic [3:0]    i_available_mask,
    input  logic [15:0]   i_demand_value,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  lls_pkg::t_cmd i_cmd,
    input  logic          i_out_ready,
    output logic [2:0]    o_n,
    output lls_pkg::t_sts o_sts,
    output logic          o_res_free,
    output logic          o_out_valid,
    output logic [1:0]    o_member_index,
    output logic          o_drive_on,
    output logic [6:0]    o_duty_percent,
    output logic [15:0]   o_member_load,
    output logic [1:0]    o_lead_index,
    output logic          o_last_result
);
    localparam logic [39:0] RT_MAX = '1;
    localparam int unsigned QW = lls_pkg::DIV_W;

    // Configuration.
    logic [2:0] r_count;
    logic r_wear, r_en;
    logic [31:0] r_interval;
    logic [15:0] r_cap [4];
    // State.
    logic [1:0] r_lead;
    logic [31:0] r_since;
    logic [15:0] r_demand;
    logic [39:0] r_rt [4];
    logic [15:0] r_load [4];
    logic [3:0] r_avail;
    // Captured beat.
    logic [1:0] r_op;
    logic [15:0] r_el, r_dv;
    logic [3:0] r_mask;
    // Rotation scan.
    logic r_found;
    logic [1:0] r_best;
    logic [39:0] r_low;
    // Sharing.
    logic [17:0] r_total;
    logic [15:0] r_rem;
    logic [1:0] r_cur;
    logic [48:0] r_num;
    logic [48:0] r_q;
    logic [17:0] r_div;
    logic [17:0] r_r;
    logic [15:0] r_share;
    // Result register.
    logic r_ov;
    logic [1:0] r_mi, r_li;
    logic r_on, r_last;
    logic [6:0] r_duty;
    logic [15:0] r_ml;

    logic [2:0] w_n;
    logic [1:0] w_lead_eff;
    logic [32:0] w_since_sum;
    logic [40:0] w_rt_sum;
    logic [1:0] w_rr;
    logic [18:0] w_trial;
    logic [15:0] w_cap_cur;
    logic [1:0] w_next;
    logic [15:0] w_sh_cl;
    logic w_more;

    assign w_n = (r_count > 3'(MEMBERS)) ? 3'(MEMBERS) : r_count;
    assign o_n = r_count;
    assign w_lead_eff = ({1'b0, r_lead} < w_n) ? r_lead : 2'd0;
    assign w_since_sum = {1'b0, r_since} + {17'd0, r_el};
    assign w_rt_sum = {1'b0, r_rt[i_cmd.idx]} + {25'd0, r_el};
    assign w_cap_cur = r_cap[r_cur];
    assign w_next = ({1'b0, r_cur} + 3'd1 >= w_n) ? 2'd0 : r_cur + 2'd1;
    assign w_trial = {r_r, r_q[QW-1]} - {1'b0, r_div};

    // Round-robin pick: first available member after the lead, cyclic within count.
    always_comb begin
        logic [1:0] c;
        logic hit;
        w_rr = w_lead_eff;
        hit = 1'b0;
        c = w_lead_eff;
        for (int k = 0; k < 3; k++) begin
            c = ({1'b0, c} + 3'd1 >= w_n) ? 2'd0 : c + 2'd1;
            if (!hit && (k + 1 < int'(w_n)) && r_avail[c]) begin
                hit = 1'b1;
                w_rr = c;
            end
        end
    end

    // Another available member lies ahead of the cursor before the walk returns to
    // its starting member.
    always_comb begin
        logic [1:0] p;
        logic stop;
        w_more = 1'b0;
        stop = 1'b0;
        p = r_cur;
        for (int k = 0; k < 3; k++) begin
            p = ({1'b0, p} + 3'd1 >= w_n) ? 2'd0 : p + 2'd1;
            if (p == w_lead_eff) stop = 1'b1;
            if (!stop && r_avail[p]) w_more = 1'b1;
        end
    end

    assign w_sh_cl = (r_q[48:16] != '0 || r_q[15:0] > w_cap_cur) ? w_cap_cur : r_q[15:0];

    // Status back to the controller.
    always_comb begin
        o_sts.op = lls_pkg::t_op'(r_op);
        o_sts.enabled = r_en;
        o_sts.rot_due = (r_interval != 32'd0) &&
            ((w_since_sum[32] ? 32'hFFFF_FFFF : w_since_sum[31:0]) >= r_interval);
        o_sts.n_zero = (w_n == 3'd0);
        o_sts.total_zero = (r_total == 18'd0) || (r_avail & ~(4'hF << w_n)) == 4'd0;
        o_sts.remaining_zero = (r_rem == 16'd0);
        o_sts.cur_avail = r_avail[r_cur];
    end

    assign o_res_free = !r_ov || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd4;
            r_wear <= 1'b0;
            r_interval <= 32'd0;
            r_en <= 1'b1;
            for (int m = 0; m < 4; m++) r_cap[m] <= 16'd0;
        end else if (i_cfg_we) begin
            case (lls_pkg::t_cfg_idx'(i_cfg_idx))
                lls_pkg::CFG_COUNT:    r_count <= i_cfg_data[2:0];
                lls_pkg::CFG_WEAR:     r_wear <= i_cfg_data[0];
                lls_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                lls_pkg::CFG_ENABLE:   r_en <= i_cfg_data[0];
                default:               r_cap[i_cfg_idx[1:0]] <= i_cfg_data[15:0];
            endcase
        end
    end

    // Beat capture and working registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_operation;
            r_el <= i_elapsed_ms;
            r_mask <= i_available_mask;
            r_dv <= i_demand_value;
        end
        if (i_cmd.rot_start) begin
            r_found <= 1'b0;
            r_best <= 2'd0;
            r_low <= 40'd0;
        end
        if (i_cmd.rot_step && r_avail[i_cmd.idx] && (!r_found || r_rt[i_cmd.idx] < r_low)) begin
            r_found <= 1'b1;
            r_low <= r_rt[i_cmd.idx];
            r_best <= i_cmd.idx;
        end
        if (i_cmd.sum_start) r_total <= 18'd0;
        if (i_cmd.sum_step && r_avail[i_cmd.idx])
            r_total <= r_total + {2'd0, r_cap[i_cmd.idx]};
        if (i_cmd.sh_start) begin
            r_rem <= r_demand;
            r_cur <= w_lead_eff;
        end
        if (i_cmd.sh_skip || i_cmd.sh_emit) r_cur <= w_next;
        if (i_cmd.sh_mul) begin
            r_num <= {17'd0, 32'(w_cap_cur) * 32'(r_demand)};
            r_div <= r_total;
        end
        if (i_cmd.sh_duty_mul) begin
            r_num <= {26'd0, 23'(r_share) * 23'(lls_pkg::PCT)};
            r_div <= {2'd0, w_cap_cur == 16'd0 ? 16'd1 : w_cap_cur};
        end
        if (i_cmd.div_start) begin
            r_q <= r_num;
            r_r <= 18'd0;
        end
        if (i_cmd.div_step) begin
            if (!w_trial[18]) begin
                r_r <= w_trial[17:0];
                r_q <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_r <= {r_r[16:0], r_q[QW-1]};
                r_q <= {r_q[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.sh_share) begin
            r_share <= w_sh_cl;
            r_rem <= (w_sh_cl >= r_rem) ? 16'd0 : r_rem - w_sh_cl;
        end
    end

    // Group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 2'd0;
            r_since <= 32'd0;
            r_demand <= 16'd0;
            r_avail <= 4'd0;
            for (int m = 0; m < 4; m++) begin
                r_rt[m] <= 40'd0;
                r_load[m] <= 16'd0;
            end
        end else begin
            if (i_cmd.set_demand) r_demand <= r_dv;
            if (i_cmd.timer_add) begin
                r_since <= w_since_sum[32] ? 32'hFFFF_FFFF : w_since_sum[31:0];
                if (r_en) r_avail <= r_mask;
            end
            if (i_cmd.rot_commit) begin
                if (r_wear) begin
                    if (r_found && r_best != r_lead) begin
                        r_lead <= r_best;
                        r_since <= 32'd0;
                    end
                end else begin
                    r_lead <= w_rr;
                    r_since <= 32'd0;
                end
            end
            if (i_cmd.run_add && r_load[i_cmd.idx] != 16'd0)
                r_rt[i_cmd.idx] <= w_rt_sum[40] ? RT_MAX : w_rt_sum[39:0];
            if (i_cmd.sh_share) r_load[r_cur] <= w_sh_cl;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.sh_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // The beat is the last of its tick once the demand is met or no member is left.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_emit) begin
            r_mi <= r_cur;
            r_on <= (r_share != 16'd0);
            r_duty <= (w_cap_cur == 16'd0) ? 7'd0 : r_q[6:0];
            r_ml <= r_share;
            r_li <= r_lead;
            r_last <= (r_rem == 16'd0) || !w_more;
        end
    end

    assign o_out_valid = r_ov;
    assign o_member_index = r_mi;
    assign o_drive_on = r_on;
    assign o_duty_percent = r_duty;
    assign o_member_load = r_ml;
    assign o_lead_index = r_li;
    assign o_last_result = r_last;

    `LLS_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.sh_emit, (!r_ov || i_out_ready),
        "result overwritten while still pending")
    `LLS_ASSERT_NXT(a_share_cap, i_clk, i_rst_n, i_cmd.sh_share, (r_share <= r_cap[r_cur]),
        "share exceeds member capacity")
    `LLS_ASSERT_IMP(a_duty_range, i_clk, i_rst_n, r_ov, (r_duty <= 7'd100),
        "duty above one hundred percent")
endmodule

/* rtl/lead_lag_load_sharing.sv */
// Top level of the lead/lag load sharing block.
//  channel | direction | handshake              | payload
//  input   | in        | i_in_valid/o_in_ready  | operation, elapsed, mask, demand
//  result  | out       | o_out_valid/i_out_ready| member, drive, duty, load, lead, last
//  config  | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
// Set demand and force rotation need no sharing pass. A tick updates the timer and, when
// enabled, rotates when due, adds runtimes, sums capacities and serves available members
// until the demand is met, with the 49-step shared restoring divider forming share and duty.
// Reset is synchronous and clears configuration, group state and result valid only.
// A stalled result holds the datapath before the next member is emitted.
module lead_lag_load_sharing #(
    parameter int unsigned MEMBERS = lls_pkg::MEMBERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_elapsed_ms,
    input  logic [3:0]  i_available_mask,
    input  logic [15:0] i_demand_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_member_index,
    output logic        o_drive_on,
    output logic [6:0]  o_duty_percent,
    output logic [15:0] o_member_load,
    output logic [1:0]  o_lead_index,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    lls_pkg::t_cmd w_cmd;
    lls_pkg::t_sts w_sts;
    logic [2:0] w_n;
    logic w_free;

    lls_ctrl #(.MEMBERS(MEMBERS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_res_free(w_free), .i_n(w_n), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lls_dp #(.MEMBERS(MEMBERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_operation(i_operation),
        .i_elapsed_ms(i_elapsed_ms), .i_available_mask(i_available_mask),
        .i_demand_value(i_demand_value), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_cmd(w_cmd), .i_out_ready(i_out_ready), .o_n(w_n),
        .o_sts(w_sts), .o_res_free(w_free), .o_out_valid(o_out_valid),
        .o_member_index(o_member_index), .o_drive_on(o_drive_on),
        .o_duty_percent(o_duty_percent), .o_member_load(o_member_load),
        .o_lead_index(o_lead_index), .o_last_result(o_last_result)
    );
endmodule
